// ----- sv/asd_pkg.sv -----
// ----------------------------------------------------------------------------
// asd_pkg
// Shared types and constants of the adaptive stride decimator.
// ----------------------------------------------------------------------------
package asd_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam int TIME_W = 32;
    localparam int VAL_W  = 48;
    localparam int ROW_W  = TIME_W + VAL_W;
    localparam int EXP_W  = 5;
    localparam int CFG_W  = 32;
    localparam int ADDR_W = 2;

    localparam logic [TIME_W-1:0] WINDOW_SPAN = TIME_W'(366 * 86400);
    localparam logic [EXP_W-1:0]  EXP_MAX     = EXP_W'(31);
    localparam logic [CNT_W-1:0]  FILL_MIN    = CNT_W'(2);
    localparam logic [CNT_W-1:0]  FILL_MAX    = CNT_W'(STORE_DEPTH);

    localparam logic [ADDR_W-1:0] REG_WINDOW_FROM   = 2'd0;
    localparam logic [ADDR_W-1:0] REG_WINDOW_TO     = 2'd1;
    localparam logic [ADDR_W-1:0] REG_WANTED_POINTS = 2'd2;

    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_COMPACT,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load;
        logic check;
        logic compact;
        logic drain;
    } cmd_t;

    typedef struct packed {
        logic trigger;
        logic compact_done;
        logic drain_done;
    } status_t;

endpackage

// ----- sv/adaptive_stride_decimator.sv -----
// ----------------------------------------------------------------------------
// adaptive_stride_decimator
// Keeps an evenly spread subset of timestamped sensor rows inside a window.
// ----------------------------------------------------------------------------
// An offer (op 0) keeps busy high while the row is checked; when a stored
// row brings the store to or beyond its fill level, busy stays high while
// the store is compacted through its single read port and single write
// port. A drain (op 1) of n kept points keeps busy high while they are read
// out (one result for an empty store) and delivers one result per cycle on
// result_strobe, the first after the state and result registers. Results
// are shown for a single cycle and cannot be held off. Configuration must be
// written through cfg_we/cfg_addr/cfg_wdata only while idle (not enforced).
// ----------------------------------------------------------------------------
module adaptive_stride_decimator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        cfg_we,
    input  logic [asd_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [asd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic                        op,
    input  logic [31:0]                 sample_time,
    input  logic [15:0]                 co2_ppm,
    input  logic signed [15:0]          temp_tenths,
    input  logic [15:0]                 humid_tenths,
    output logic                        result_strobe,
    output logic [31:0]                 point_time,
    output logic [15:0]                 point_co2,
    output logic signed [15:0]          point_temp,
    output logic [15:0]                 point_humid,
    output logic                        point_valid,
    output logic                        last_point,
    output logic [6:0]                  points_total
);

    asd_pkg::cmd_t    cmd;
    asd_pkg::status_t status;

    asd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    asd_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .sample_time   (sample_time),
        .co2_ppm       (co2_ppm),
        .temp_tenths   (temp_tenths),
        .humid_tenths  (humid_tenths),
        .cmd           (cmd),
        .status        (status),
        .result_strobe (result_strobe),
        .point_time    (point_time),
        .point_co2     (point_co2),
        .point_temp    (point_temp),
        .point_humid   (point_humid),
        .point_valid   (point_valid),
        .last_point    (last_point),
        .points_total  (points_total)
    );

    a_result_after_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_strobe |-> $past(busy)
    ) else $error("result without a drain in progress");

    a_empty_drain: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_strobe && !point_valid) |-> (last_point && points_total == 7'd0)
    ) else $error("empty drain result malformed");

    a_request_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy
    ) else $error("accepted request did not raise busy");

    a_count_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result_strobe && point_valid) |-> (points_total != 7'd0)
    ) else $error("kept point with zero total");

endmodule

// ----- sv/asd_ram.sv -----
// ----------------------------------------------------------------------------
// asd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module asd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/asd_ctrl.sv -----
// ----------------------------------------------------------------------------
// asd_ctrl
// Sequencer: offer check, store compaction and drain.
// ----------------------------------------------------------------------------
module asd_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic             op,
    input  asd_pkg::status_t status,
    output asd_pkg::cmd_t    cmd,
    output logic             busy
);

    asd_pkg::state_t state_reg;
    asd_pkg::state_t state_next;
    logic            accept;

    assign busy   = (state_reg != asd_pkg::ST_IDLE);
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= asd_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            asd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = (op == asd_pkg::OP_DRAIN) ? asd_pkg::ST_DRAIN
                                                           : asd_pkg::ST_CHECK;
                end
            end
            asd_pkg::ST_CHECK:
            begin
                state_next = status.trigger ? asd_pkg::ST_COMPACT : asd_pkg::ST_IDLE;
            end
            asd_pkg::ST_COMPACT:
            begin
                if (status.compact_done)
                begin
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            asd_pkg::ST_DRAIN:
            begin
                if (status.drain_done)
                begin
                    state_next = asd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = asd_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd         = '0;
        cmd.load    = accept;
        cmd.check   = (state_reg == asd_pkg::ST_CHECK);
        cmd.compact = (state_reg == asd_pkg::ST_COMPACT);
        cmd.drain   = (state_reg == asd_pkg::ST_DRAIN);
    end

endmodule

// ----- sv/asd_dp.sv -----
// ----------------------------------------------------------------------------
// asd_dp
// Datapath: window registers, stride test, kept-row store and result stage.
// ----------------------------------------------------------------------------
module asd_dp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [asd_pkg::ADDR_W-1:0]  cfg_addr,
    input  logic [asd_pkg::CFG_W-1:0]   cfg_wdata,
    input  logic [31:0]                 sample_time,
    input  logic [15:0]                 co2_ppm,
    input  logic signed [15:0]          temp_tenths,
    input  logic [15:0]                 humid_tenths,
    input  asd_pkg::cmd_t               cmd,
    output asd_pkg::status_t            status,
    output logic                        result_strobe,
    output logic [31:0]                 point_time,
    output logic [15:0]                 point_co2,
    output logic signed [15:0]          point_temp,
    output logic [15:0]                 point_humid,
    output logic                        point_valid,
    output logic                        last_point,
    output logic [6:0]                  points_total
);

    logic [asd_pkg::TIME_W-1:0] win_from_reg;
    logic [asd_pkg::TIME_W-1:0] win_to_reg;
    logic [6:0]                 wanted_reg;
    logic [asd_pkg::TIME_W-1:0] lo_reg;
    logic [asd_pkg::TIME_W-1:0] lo_next;
    logic [asd_pkg::CNT_W-1:0]  fill_reg;
    logic [asd_pkg::CNT_W-1:0]  fill_next;

    logic [asd_pkg::TIME_W-1:0] ts_reg;
    logic [asd_pkg::VAL_W-1:0]  val_reg;

    logic [asd_pkg::CNT_W-1:0]  kept_reg;
    logic [asd_pkg::EXP_W-1:0]  exp_reg;
    logic [31:0]                match_reg;
    logic [asd_pkg::CNT_W-1:0]  step_reg;
    logic [asd_pkg::CNT_W-1:0]  half_reg;

    logic                       strobe_reg;
    logic                       has_reg;
    logic                       last_reg;
    logic [asd_pkg::CNT_W-1:0]  total_reg;

    logic [asd_pkg::TIME_W:0]   diff;
    logic [asd_pkg::TIME_W-1:0] earliest;
    logic [31:0]                mask;
    logic                       in_win;
    logic                       take;
    logic [asd_pkg::CNT_W-1:0]  kept_inc;

    logic                       ram_we;
    logic [asd_pkg::IDX_W-1:0]  ram_waddr;
    logic [asd_pkg::ROW_W-1:0]  ram_wdata;
    logic [asd_pkg::IDX_W-1:0]  ram_raddr;
    logic [asd_pkg::ROW_W-1:0]  ram_rdata;

    // window start clamp and fill level, refreshed every cycle
    always_comb
    begin
        diff     = {1'b0, win_to_reg} - {1'b0, asd_pkg::WINDOW_SPAN};
        earliest = diff[asd_pkg::TIME_W] ? '0 : diff[asd_pkg::TIME_W-1:0];
        lo_next  = (win_from_reg < earliest) ? earliest : win_from_reg;
        priority if (wanted_reg < asd_pkg::FILL_MIN)
        begin
            fill_next = asd_pkg::FILL_MIN;
        end
        else if (wanted_reg > asd_pkg::FILL_MAX)
        begin
            fill_next = asd_pkg::FILL_MAX;
        end
        else
        begin
            fill_next = wanted_reg;
        end
    end

    always_comb
    begin
        mask     = ~({32{1'b1}} << exp_reg);
        in_win   = (ts_reg >= lo_reg) && (ts_reg <= win_to_reg);
        take     = in_win && ((match_reg & mask) == '0);
        kept_inc = kept_reg + asd_pkg::CNT_W'(1);

        status              = '0;
        status.trigger      = take && (kept_inc >= fill_reg);
        status.compact_done = (step_reg == half_reg);
        status.drain_done   = (kept_reg == '0) ||
                              (step_reg == kept_reg - asd_pkg::CNT_W'(1));
    end

    // store port selection
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = kept_reg[asd_pkg::IDX_W-1:0];
        ram_wdata = {ts_reg, val_reg};
        ram_raddr = step_reg[asd_pkg::IDX_W-1:0];
        if (cmd.check)
        begin
            ram_we = take;
        end
        else if (cmd.compact)
        begin
            ram_we    = (step_reg != '0);
            ram_waddr = asd_pkg::IDX_W'(step_reg - asd_pkg::CNT_W'(1));
            ram_wdata = ram_rdata;
            ram_raddr = asd_pkg::IDX_W'({step_reg, 1'b0});
        end
    end

    asd_ram #(
        .WIDTH (asd_pkg::ROW_W),
        .DEPTH (asd_pkg::STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_from_reg <= '0;
            win_to_reg   <= '1;
            wanted_reg   <= 7'd64;
            lo_reg       <= '0;
            fill_reg     <= asd_pkg::FILL_MAX;
            kept_reg     <= '0;
            exp_reg      <= '0;
            match_reg    <= '0;
            step_reg     <= '0;
            half_reg     <= '0;
            strobe_reg   <= 1'b0;
            has_reg      <= 1'b0;
            last_reg     <= 1'b0;
            total_reg    <= '0;
        end
        else
        begin
            lo_reg     <= lo_next;
            fill_reg   <= fill_next;
            strobe_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_addr)
                    asd_pkg::REG_WINDOW_FROM:   win_from_reg <= cfg_wdata;
                    asd_pkg::REG_WINDOW_TO:     win_to_reg   <= cfg_wdata;
                    asd_pkg::REG_WANTED_POINTS: wanted_reg   <= cfg_wdata[6:0];
                    default:                    ;
                endcase
            end

            if (cmd.load)
            begin
                step_reg <= '0;
            end

            if (cmd.check)
            begin
                if (in_win)
                begin
                    match_reg <= match_reg + 32'd1;
                end
                if (take)
                begin
                    kept_reg <= kept_inc;
                end
                if (status.trigger)
                begin
                    half_reg <= (kept_inc + asd_pkg::CNT_W'(1)) >> 1;
                    step_reg <= '0;
                end
            end

            if (cmd.compact)
            begin
                step_reg <= step_reg + asd_pkg::CNT_W'(1);
                if (status.compact_done)
                begin
                    kept_reg <= half_reg;
                    if (exp_reg < asd_pkg::EXP_MAX)
                    begin
                        exp_reg <= exp_reg + asd_pkg::EXP_W'(1);
                    end
                end
            end

            if (cmd.drain)
            begin
                step_reg   <= step_reg + asd_pkg::CNT_W'(1);
                strobe_reg <= 1'b1;
                has_reg    <= (kept_reg != '0);
                last_reg   <= status.drain_done;
                total_reg  <= kept_reg;
                if (status.drain_done)
                begin
                    kept_reg  <= '0;
                    exp_reg   <= '0;
                    match_reg <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            ts_reg  <= sample_time;
            val_reg <= {co2_ppm, temp_tenths, humid_tenths};
        end
    end

    assign result_strobe = strobe_reg;
    assign point_valid   = has_reg;
    assign last_point    = last_reg;
    assign points_total  = has_reg ? 7'(total_reg) : '0;
    assign point_time    = has_reg ? ram_rdata[asd_pkg::ROW_W-1 -: 32] : '0;
    assign point_co2     = has_reg ? ram_rdata[47:32] : '0;
    assign point_temp    = has_reg ? ram_rdata[31:16] : '0;
    assign point_humid   = has_reg ? ram_rdata[15:0] : '0;

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the adaptive stride decimator.
// Requests (offers and drains) are driven through the start/busy handshake.
// A built-in predictor tracks the window, the stride and the store, and works
// out the points that every drain should deliver. A checker compares each
// strobed result, field by field, against the oldest pending point.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 2000;
    localparam int SHOWN_ERRORS  = 10;

    typedef struct {
        logic [31:0]        ptime;
        logic [15:0]        co2;
        logic signed [15:0] temp;
        logic [15:0]        humid;
        logic               valid;
        logic               last;
        logic [6:0]         total;
    } kept_point_t;

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic                        cfg_we;
    logic [asd_pkg::ADDR_W-1:0]  cfg_addr;
    logic [asd_pkg::CFG_W-1:0]   cfg_wdata;
    logic                        op;
    logic [31:0]                 sample_time;
    logic [15:0]                 co2_ppm;
    logic signed [15:0]          temp_tenths;
    logic [15:0]                 humid_tenths;
    logic                        result_strobe;
    logic [31:0]                 point_time;
    logic [15:0]                 point_co2;
    logic signed [15:0]          point_temp;
    logic [15:0]                 point_humid;
    logic                        point_valid;
    logic                        last_point;
    logic [6:0]                  points_total;

    // predictor state
    logic [31:0]         win_lo_reg;
    logic [31:0]         win_hi_reg;
    logic [6:0]          fill_reg;
    logic [31:0]         held_time [asd_pkg::STORE_DEPTH];
    logic [47:0]         held_reading [asd_pkg::STORE_DEPTH];
    int unsigned         held_count;
    int unsigned         stride_log2;
    logic [31:0]         row_tally;

    kept_point_t         due_points[$];
    int unsigned         bad_points;
    int unsigned         stall_cycles;
    logic                calm;

    adaptive_stride_decimator DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .op            (op),
        .sample_time   (sample_time),
        .co2_ppm       (co2_ppm),
        .temp_tenths   (temp_tenths),
        .humid_tenths  (humid_tenths),
        .result_strobe (result_strobe),
        .point_time    (point_time),
        .point_co2     (point_co2),
        .point_temp    (point_temp),
        .point_humid   (point_humid),
        .point_valid   (point_valid),
        .last_point    (last_point),
        .points_total  (points_total)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [31:0] window_start();
        logic [31:0] earliest;
        earliest = (win_hi_reg > asd_pkg::WINDOW_SPAN) ?
                   win_hi_reg - asd_pkg::WINDOW_SPAN : 32'd0;
        return (win_lo_reg < earliest) ? earliest : win_lo_reg;
    endfunction

    function automatic int unsigned fill_target();
        int unsigned w;
        w = fill_reg;
        if (w < asd_pkg::FILL_MIN)
            w = asd_pkg::FILL_MIN;
        if (w > asd_pkg::FILL_MAX)
            w = asd_pkg::FILL_MAX;
        return w;
    endfunction

    function automatic void clear_store();
        held_count  = 0;
        stride_log2 = 0;
        row_tally   = '0;
    endfunction

    function automatic void decimate_row(input logic [31:0] t, input logic [47:0] reading);
        logic [31:0] mask;
        int unsigned w;
        if (t < window_start() || t > win_hi_reg)
            return;
        mask = (32'd1 << stride_log2) - 32'd1;
        if ((row_tally & mask) == 32'd0)
        begin
            if (held_count < asd_pkg::STORE_DEPTH)
            begin
                held_time[held_count]    = t;
                held_reading[held_count] = reading;
                held_count++;
            end
            if (held_count >= fill_target() || held_count >= asd_pkg::STORE_DEPTH)
            begin
                w = 0;
                for (int unsigned r = 0; r < held_count; r += 2)
                begin
                    held_time[w]    = held_time[r];
                    held_reading[w] = held_reading[r];
                    w++;
                end
                held_count = w;
                if (stride_log2 < asd_pkg::EXP_MAX)
                    stride_log2++;
            end
        end
        row_tally = row_tally + 32'd1;
    endfunction

    function automatic void drain_points();
        kept_point_t p;
        int unsigned n;
        n = held_count;
        if (n == 0)
        begin
            p = '{ptime: '0, co2: '0, temp: '0, humid: '0, valid: 1'b0, last: 1'b1,
                  total: '0};
            due_points.push_back(p);
        end
        for (int unsigned k = 0; k < n; k++)
        begin
            p.ptime = held_time[k];
            p.co2   = held_reading[k][47:32];
            p.temp  = held_reading[k][31:16];
            p.humid = held_reading[k][15:0];
            p.valid = 1'b1;
            p.last  = (k + 1 == n);
            p.total = 7'(n);
            due_points.push_back(p);
        end
        clear_store();
    endfunction

    // ------------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        kept_point_t want;
        if (rst_n && result_strobe)
        begin
            if (due_points.size() == 0)
            begin
                bad_points++;
                if (bad_points <= SHOWN_ERRORS)
                    $display("unexpected point: time %0h valid %0b last %0b", point_time,
                             point_valid, last_point);
            end
            else
            begin
                want = due_points.pop_front();
                if (want.ptime !== point_time || want.co2 !== point_co2 ||
                    want.temp !== point_temp || want.humid !== point_humid ||
                    want.valid !== point_valid || want.last !== last_point ||
                    want.total !== points_total)
                begin
                    bad_points++;
                    if (bad_points <= SHOWN_ERRORS)
                    begin
                        $display({"point mismatch: exp time %0h co2 %0d temp %0d",
                                  " hum %0d v %0b l %0b n %0d"},
                                 want.ptime, want.co2, want.temp, want.humid, want.valid,
                                 want.last, want.total);
                        $display({"                got time %0h co2 %0d temp %0d",
                                  " hum %0d v %0b l %0b n %0d"},
                                 point_time, point_co2, point_temp, point_humid, point_valid,
                                 last_point, points_total);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_strobe)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------
    task automatic issue(input logic o, input logic [31:0] t, input logic [15:0] c,
                         input logic [15:0] tp, input logic [15:0] h);
        int unsigned gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start        = 1'b1;
        op           = o;
        sample_time  = t;
        co2_ppm      = c;
        temp_tenths  = tp;
        humid_tenths = h;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (o == asd_pkg::OP_DRAIN)
            drain_points();
        else
            decimate_row(t, {c, tp, h});
    endtask

    task automatic offer_row(input logic [31:0] t);
        issue(asd_pkg::OP_OFFER, t, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    task automatic drain_all();
        issue(asd_pkg::OP_DRAIN, $urandom, 16'($urandom), 16'($urandom), 16'($urandom));
    endtask

    // wait until the block is quiet before touching registers
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (due_points.size() != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [asd_pkg::ADDR_W-1:0] addr,
                             input logic [asd_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_addr  = addr;
        cfg_wdata = data;
        @(negedge clk);
        cfg_we    = 1'b0;
        case (addr)
            asd_pkg::REG_WINDOW_FROM:   win_lo_reg = data;
            asd_pkg::REG_WINDOW_TO:     win_hi_reg = data;
            asd_pkg::REG_WANTED_POINTS: fill_reg   = data[6:0];
            default:                    ;
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_empty_drain();
        drain_all();
    endtask

    task automatic test_default_window();
        logic [31:0] lo;
        lo = window_start();
        issue(asd_pkg::OP_OFFER, 32'hFFFF_FFFF, 16'hFFFF, 16'h8000, 16'hFFFF);
        issue(asd_pkg::OP_OFFER, 32'd0, 16'h1234, 16'h0001, 16'h4321);
        issue(asd_pkg::OP_OFFER, lo - 32'd1, 16'hAAAA, 16'h5555, 16'hAAAA);
        issue(asd_pkg::OP_OFFER, lo, 16'h0000, 16'h7FFF, 16'h0000);
        drain_all();
    endtask

    task automatic test_clamp_near_zero();
        settle();
        write_reg(asd_pkg::REG_WINDOW_FROM, 32'd0);
        write_reg(asd_pkg::REG_WINDOW_TO, 32'd1000);
        offer_row(32'd0);
        offer_row(32'd1000);
        offer_row(32'd1001);
        drain_all();
    endtask

    task automatic test_inverted_window();
        settle();
        write_reg(asd_pkg::REG_WINDOW_FROM, 32'd500);
        write_reg(asd_pkg::REG_WINDOW_TO, 32'd100);
        offer_row(32'd300);
        offer_row(32'd100);
        offer_row(32'd500);
        drain_all();
    endtask

    task automatic test_fill_minimum();
        settle();
        write_reg(asd_pkg::REG_WINDOW_FROM, 32'd0);
        write_reg(asd_pkg::REG_WINDOW_TO, 32'd100000);
        write_reg(asd_pkg::REG_WANTED_POINTS, 32'd0);
        for (int i = 0; i < 4; i++)
            offer_row(32'd10 * i);
        drain_all();
    endtask

    task automatic test_fill_lowered();
        settle();
        write_reg(asd_pkg::REG_WANTED_POINTS, 32'd64);
        for (int i = 0; i < 4; i++)
            offer_row(32'd100 + i);
        settle();
        write_reg(asd_pkg::REG_WANTED_POINTS, 32'd3);
        offer_row(32'd200);
        drain_all();
    endtask

    task automatic test_random_phases();
        logic [31:0] f;
        logic [31:0] t;
        logic [31:0] lo;
        logic [6:0]  want;
        int unsigned rows;
        for (int phase = 0; phase < 9; phase++)
        begin
            settle();
            calm = (phase >= 7);
            case (phase % 5)
                0:
                begin
                    f = 32'd0;
                    t = 32'hFFFF_FFFF;
                end
                1:
                begin
                    t = $urandom;
                    f = t - $urandom_range(0, 5000);
                end
                2:
                begin
                    t = $urandom_range(0, asd_pkg::WINDOW_SPAN);
                    f = $urandom_range(0, t);
                end
                3:
                begin
                    f = $urandom;
                    t = $urandom;
                end
                default:
                begin
                    f = 32'd0;
                    t = $urandom;
                end
            endcase
            case (phase)
                0:       want = 7'd127;
                1:       want = 7'd1;
                2:       want = 7'd64;
                default: want = 7'($urandom_range(2, 10));
            endcase
            write_reg(asd_pkg::REG_WINDOW_FROM, f);
            write_reg(asd_pkg::REG_WINDOW_TO, t);
            write_reg(asd_pkg::REG_WANTED_POINTS, {25'($urandom), want});
            lo   = window_start();
            rows = (phase == 0) ? 70 : 10;
            // the first phase fills the whole store before any drain
            for (int unsigned k = 0; k < rows; k++)
            begin
                if (phase != 0 && $urandom_range(0, 12) == 0)
                    drain_all();
                else if (lo <= t && (phase == 0 || $urandom_range(0, 9) != 0))
                    offer_row($urandom_range(t, lo));
                else
                    offer_row($urandom);
            end
            drain_all();
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        start        = 1'b0;
        cfg_we       = 1'b0;
        cfg_addr     = '0;
        cfg_wdata    = '0;
        op           = asd_pkg::OP_OFFER;
        sample_time  = '0;
        co2_ppm      = '0;
        temp_tenths  = '0;
        humid_tenths = '0;
        win_lo_reg   = 32'd0;
        win_hi_reg   = 32'hFFFF_FFFF;
        fill_reg     = 7'd64;
        bad_points   = 0;
        calm         = 1'b0;
        clear_store();
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        test_empty_drain();
        test_default_window();
        test_clamp_near_zero();
        test_inverted_window();
        test_fill_minimum();
        test_fill_lowered();
        test_random_phases();

        settle();
        if (bad_points == 0 && due_points.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- adaptive_stride_decimator.f -----
sv/asd_pkg.sv
sv/asd_ram.sv
sv/asd_ctrl.sv
sv/asd_dp.sv
sv/adaptive_stride_decimator.sv
tb/tb.sv
